FILE: hdl/fama_pkg.sv
package fama_pkg;

   // Block geometry
   localparam int CHANNELS   = 5;
   localparam int RING_DEPTH = 8;
   localparam int CAL_REGS   = 5;

   // Field widths
   localparam int DATA_W    = 16;
   localparam int CH_W      = 3;
   localparam int FILL_W    = 7;
   localparam int CSR_IDX_W = 3;

   // Derived widths
   localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int HEAD_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W     = $clog2(RING_DEPTH + 1);
   localparam int SUM_W     = DATA_W + $clog2(RING_DEPTH);
   localparam int MEM_DEPTH = CHANNELS * RING_DEPTH;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   // Marker value after reset, also the last value of every channel
   localparam logic signed [DATA_W-1:0] MARKER_RESET = -16'sd3146;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MARKER   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CAL_BASE = 3'd1;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic read;
      logic update;
      logic div_start;
      logic load_out;
   } fama_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic empty;
      logic div_busy;
      logic out_free;
   } fama_status_type;

endpackage

FILE: hdl/fama_div.sv
module fama_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [fama_pkg::SUM_W-1:0]     dividend,
   input  logic        [fama_pkg::CNT_W-1:0]     divisor,
   output logic                                  busy,
   output logic        [fama_pkg::SUM_W-1:0]     quot_mag,
   output logic                                  quot_neg
);

   localparam int SW     = fama_pkg::SUM_W;
   localparam int CW     = fama_pkg::CNT_W;
   localparam int STEP_W = $clog2(SW + 1);

   logic [SW-1:0]     q_ff, q_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [CW-1:0]     div_ff;
   logic              neg_ff;
   logic [STEP_W-1:0] step_ff;
   logic [CW:0]       trial, diff;
   logic              ge;
   logic [SW-1:0]     mag;

   // magnitude of the dividend, sign kept aside
   assign mag = dividend[SW-1] ? SW'(-dividend) : SW'(dividend);

   // one restoring step a cycle
   always_comb begin
      trial  = {rem_ff, q_ff[SW-1]};
      diff   = trial - {1'b0, div_ff};
      ge     = trial >= {1'b0, div_ff};
      rem_in = ge ? diff[CW-1:0] : trial[CW-1:0];
      q_in   = {q_ff[SW-2:0], ge};
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (start) begin
         step_ff <= STEP_W'(SW);
      end else if (busy) begin
         step_ff <= step_ff - 1'b1;
      end
   end

   // quotient and partial remainder
   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= mag;
         rem_ff <= '0;
         div_ff <= divisor;
         neg_ff <= dividend[SW-1];
      end else if (busy) begin
         q_ff   <= q_in;
         rem_ff <= rem_in;
      end
   end

   assign busy     = step_ff != '0;
   assign quot_mag = q_ff;
   assign quot_neg = neg_ff;

endmodule

FILE: hdl/fama_dpath.sv
module fama_dpath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  fama_pkg::fama_cmd_type                   cmd,
   output fama_pkg::fama_status_type                status,
   input  logic        [fama_pkg::CH_W-1:0]         req_channel,
   input  logic signed [fama_pkg::DATA_W-1:0]       req_sample,
   input  logic                                     csr_valid,
   input  logic        [fama_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic signed [fama_pkg::DATA_W-1:0]       csr_wdata,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic        [fama_pkg::CH_W-1:0]         rsp_out_channel,
   output logic signed [fama_pkg::DATA_W-1:0]       rsp_mean_value,
   output logic                                     rsp_has_data,
   output logic        [fama_pkg::FILL_W-1:0]       rsp_fill_count,
   output logic signed [fama_pkg::DATA_W-1:0]       rsp_last_good,
   output logic                                     rsp_sample_good
);

   localparam int DW    = fama_pkg::DATA_W;
   localparam int SW    = fama_pkg::SUM_W;
   localparam int CW    = fama_pkg::CNT_W;
   localparam int HW    = fama_pkg::HEAD_W;
   localparam int AW    = fama_pkg::ADDR_W;
   localparam int POS_W = CW + 1;

   // integer part of a Q11.4 value, rounded toward zero
   function automatic logic signed [DW-5:0] int_part(input logic signed [DW-1:0] v);
      logic signed [DW-5:0] t;
      t = v[DW-1:4];
      if (v[DW-1] && (v[3:0] != 4'd0)) begin
         t = t + 1'b1;
      end
      return t;
   endfunction

   function automatic logic [AW-1:0] ring_addr(input logic [fama_pkg::CH_IDX_W-1:0] ci,
                                               input logic [HW-1:0] idx);
      return AW'(ci) * AW'(fama_pkg::RING_DEPTH) + AW'(idx);
   endfunction

   // configuration registers
   logic signed [DW-1:0] marker_ff;
   logic signed [DW-1:0] cal_ff [fama_pkg::CAL_REGS];

   // captured word
   logic        [fama_pkg::CH_W-1:0] ch_ff;
   logic signed [DW-1:0]             sample_ff;

   // per-channel state
   logic [HW-1:0]        head_ff [fama_pkg::CHANNELS];
   logic [CW-1:0]        cnt_ff  [fama_pkg::CHANNELS];
   logic signed [SW-1:0] sum_ff  [fama_pkg::CHANNELS];
   logic signed [DW-1:0] last_ff [fama_pkg::CHANNELS];

   // sample ring store
   logic [DW-1:0] ring_mem [fama_pkg::MEM_DEPTH];
   logic [DW-1:0] rd_data_ff;

   // result slot
   logic                             rsp_valid_ff;
   logic        [fama_pkg::CH_W-1:0] rsp_channel_ff;
   logic signed [DW-1:0]             rsp_mean_ff;
   logic                             rsp_has_data_ff;
   logic [fama_pkg::FILL_W-1:0]      rsp_fill_ff;
   logic signed [DW-1:0]             rsp_last_ff;
   logic                             rsp_good_ff;

   logic                            in_range;
   logic [fama_pkg::CH_IDX_W-1:0]   ch_idx;
   logic                            good;
   logic signed [DW:0]              cal_raw;
   logic signed [DW-1:0]            cal_v;
   logic [HW-1:0]                   head_c, head_inc, head_in;
   logic [CW-1:0]                   cnt_c, cnt_in;
   logic signed [SW-1:0]            sum_c, sum_in, old_ext, v_ext;
   logic signed [DW-1:0]            last_in;
   logic [POS_W-1:0]                tail, tail_wrap;
   logic                            mem_we;
   logic [AW-1:0]                   mem_waddr;
   logic                            empty;
   logic                            div_busy;
   logic [SW-1:0]                   quot_mag;
   logic                            quot_neg;
   logic [SW-1:0]                   quot;

   // channel decode
   assign in_range = ch_ff < fama_pkg::CH_W'(fama_pkg::CHANNELS);
   assign ch_idx   = in_range ? ch_ff[fama_pkg::CH_IDX_W-1:0] : '0;
   assign good     = int_part(sample_ff) != int_part(marker_ff);

   // calibrated sample, saturated
   always_comb begin
      cal_raw = {sample_ff[DW-1], sample_ff} + {cal_ff[ch_idx][DW-1], cal_ff[ch_idx]};
      if (cal_raw[DW] != cal_raw[DW-1]) begin
         cal_v = cal_raw[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      end else begin
         cal_v = cal_raw[DW-1:0];
      end
   end

   // ring bookkeeping for the current channel
   always_comb begin
      head_c    = head_ff[ch_idx];
      cnt_c     = cnt_ff[ch_idx];
      sum_c     = sum_ff[ch_idx];
      old_ext   = SW'(signed'(rd_data_ff));
      v_ext     = SW'(cal_v);
      head_inc  = (head_c == HW'(fama_pkg::RING_DEPTH - 1)) ? '0 : head_c + 1'b1;
      tail      = POS_W'(head_c) + POS_W'(cnt_c);
      tail_wrap = (tail >= POS_W'(fama_pkg::RING_DEPTH)) ?
                  tail - POS_W'(fama_pkg::RING_DEPTH) : tail;
      head_in   = head_c;
      cnt_in    = cnt_c;
      sum_in    = sum_c;
      last_in   = last_ff[ch_idx];
      mem_we    = 1'b0;
      mem_waddr = ring_addr(ch_idx, head_c);
      if (!good) begin
         // fault: drop the oldest entry
         if (cnt_c != '0) begin
            sum_in  = sum_c - old_ext;
            head_in = head_inc;
            cnt_in  = cnt_c - 1'b1;
         end
      end else begin
         last_in = cal_v;
         mem_we  = 1'b1;
         if (cnt_c < CW'(fama_pkg::RING_DEPTH)) begin
            mem_waddr = ring_addr(ch_idx, tail_wrap[HW-1:0]);
            cnt_in    = cnt_c + 1'b1;
            sum_in    = sum_c + v_ext;
         end else begin
            // full: overwrite the oldest
            head_in = head_inc;
            sum_in  = sum_c - old_ext + v_ext;
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= fama_pkg::MARKER_RESET;
         for (int i = 0; i < fama_pkg::CAL_REGS; i++) begin
            cal_ff[i] <= '0;
         end
      end else if (csr_valid) begin
         if (csr_index == fama_pkg::REG_MARKER) begin
            marker_ff <= csr_wdata;
         end
         for (int i = 0; i < fama_pkg::CAL_REGS; i++) begin
            if (csr_index == fama_pkg::REG_CAL_BASE + fama_pkg::CSR_IDX_W'(i)) begin
               cal_ff[i] <= csr_wdata;
            end
         end
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ch_ff     <= req_channel;
         sample_ff <= req_sample;
      end
   end

   // per-channel state update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fama_pkg::CHANNELS; i++) begin
            head_ff[i] <= '0;
            cnt_ff[i]  <= '0;
            sum_ff[i]  <= '0;
            last_ff[i] <= fama_pkg::MARKER_RESET;
         end
      end else if (cmd.update && in_range) begin
         head_ff[ch_idx] <= head_in;
         cnt_ff[ch_idx]  <= cnt_in;
         sum_ff[ch_idx]  <= sum_in;
         last_ff[ch_idx] <= last_in;
      end
   end

   // ring store: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.update && in_range && mem_we) begin
         ring_mem[mem_waddr] <= cal_v;
      end
      if (cmd.read) begin
         rd_data_ff <= ring_mem[ring_addr(ch_idx, head_c)];
      end
   end

   // mean
   fama_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff[ch_idx]),
      .divisor  (cnt_ff[ch_idx]),
      .busy     (div_busy),
      .quot_mag (quot_mag),
      .quot_neg (quot_neg)
   );

   assign quot  = quot_neg ? SW'(-quot_mag) : quot_mag;
   assign empty = !in_range || (cnt_ff[ch_idx] == '0);

   // result slot valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // result slot payload
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_channel_ff  <= ch_ff;
         rsp_mean_ff     <= empty ? marker_ff : quot[DW-1:0];
         rsp_has_data_ff <= !empty;
         rsp_fill_ff     <= in_range ? fama_pkg::FILL_W'(cnt_ff[ch_idx]) : '0;
         rsp_last_ff     <= in_range ? last_ff[ch_idx] : marker_ff;
         rsp_good_ff     <= good;
      end
   end

   assign status.empty    = empty;
   assign status.div_busy = div_busy;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_channel_ff;
   assign rsp_mean_value  = rsp_mean_ff;
   assign rsp_has_data    = rsp_has_data_ff;
   assign rsp_fill_count  = rsp_fill_ff;
   assign rsp_last_good   = rsp_last_ff;
   assign rsp_sample_good = rsp_good_ff;

endmodule

FILE: hdl/fama_ctrl.sv
module fama_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  fama_pkg::fama_status_type   status,
   output fama_pkg::fama_cmd_type      cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_UPDATE = 3'd2;
   localparam logic [2:0] S_START  = 3'd3;
   localparam logic [2:0] S_DIVIDE = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;

   // sequencing of one word
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_START;
         end
         S_START: begin
            if (status.empty) begin
               state_in = S_DONE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            if (!status.div_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;

   // checks
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("result loaded over a waiting word");

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> status.div_busy)
      else $error("divider did not start");

   a_read_update: assert property (@(posedge clock) disable iff (reset)
      cmd.read |=> cmd.update)
      else $error("ring read not followed by update");

   a_accept_read: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (cmd.read && req_stall))
      else $error("accepted word not processed");

endmodule

FILE: hdl/fault_aware_moving_average_top.sv
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_stall   req_channel, req_sample
// rsp      out        rsp_valid/rsp_stall   rsp_out_channel, rsp_mean_value, rsp_has_data,
//                                           rsp_fill_count, rsp_last_good, rsp_sample_good
// csr      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// One word at a time: accept, ring read, update, divider start, then the bit-serial
// divider (19 quotient bits, one bit a cycle) and a load into the result register; the
// divider is skipped when the ring ends up empty or the channel is out of range. A new
// word is taken only once the result of the last one is loaded.
// Synchronous active-high reset; a ring entry's value is used only once it is written.
// A waiting result holds in its register; the next word is taken meanwhile.
module fault_aware_moving_average_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic        [fama_pkg::CH_W-1:0]      req_channel,
   input  logic signed [fama_pkg::DATA_W-1:0]    req_sample,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic        [fama_pkg::CH_W-1:0]      rsp_out_channel,
   output logic signed [fama_pkg::DATA_W-1:0]    rsp_mean_value,
   output logic                                  rsp_has_data,
   output logic        [fama_pkg::FILL_W-1:0]    rsp_fill_count,
   output logic signed [fama_pkg::DATA_W-1:0]    rsp_last_good,
   output logic                                  rsp_sample_good,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic        [fama_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic signed [fama_pkg::DATA_W-1:0]    csr_wdata
);

   fama_pkg::fama_cmd_type    cmd;
   fama_pkg::fama_status_type status;

   // registers are always writable
   assign csr_ready = 1'b1;

   fama_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fama_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_channel (rsp_out_channel),
      .rsp_mean_value  (rsp_mean_value),
      .rsp_has_data    (rsp_has_data),
      .rsp_fill_count  (rsp_fill_count),
      .rsp_last_good   (rsp_last_good),
      .rsp_sample_good (rsp_sample_good)
   );

endmodule

FILE: test/fault_aware_moving_average_top_tb.sv
`timescale 1ns / 1ps

module fault_aware_moving_average_top_tb;

   localparam int CHANNELS   = fama_pkg::CHANNELS;
   localparam int RING_DEPTH = fama_pkg::RING_DEPTH;
   localparam int CAL_REGS   = fama_pkg::CAL_REGS;
   localparam int DATA_W     = fama_pkg::DATA_W;
   localparam int CH_W       = fama_pkg::CH_W;
   localparam int FILL_W     = fama_pkg::FILL_W;
   localparam int CSR_IDX_W  = fama_pkg::CSR_IDX_W;
   localparam logic signed [DATA_W-1:0]  MARKER_RESET = fama_pkg::MARKER_RESET;
   localparam logic [CSR_IDX_W-1:0]      REG_MARKER   = fama_pkg::REG_MARKER;
   localparam logic [CSR_IDX_W-1:0]      REG_CAL_BASE = fama_pkg::REG_CAL_BASE;

   localparam int HOLD_CYCLES = 400;
   // first index past the calibration block, written only to show it is ignored
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = REG_CAL_BASE + CSR_IDX_W'(CAL_REGS);

   typedef struct packed {
      logic [CH_W-1:0]          chan;
      logic signed [DATA_W-1:0] mean;
      logic                     has;
      logic [FILL_W-1:0]        fill;
      logic signed [DATA_W-1:0] last;
      logic                     good;
   } avg_result_type;

   logic clock;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [CH_W-1:0]             req_channel = '0;
   logic signed [DATA_W-1:0]    req_sample = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [CH_W-1:0]             rsp_out_channel;
   logic signed [DATA_W-1:0]    rsp_mean_value;
   logic                        rsp_has_data;
   logic [FILL_W-1:0]           rsp_fill_count;
   logic signed [DATA_W-1:0]    rsp_last_good;
   logic                        rsp_sample_good;
   logic                        csr_valid = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic signed [DATA_W-1:0]    csr_wdata = '0;

   // Predictor state: registers and per-channel rings
   logic signed [DATA_W-1:0] marker_q = MARKER_RESET;
   logic signed [DATA_W-1:0] cal_q [CAL_REGS] = '{default: '0};
   logic signed [DATA_W-1:0] ring_q [CHANNELS][RING_DEPTH];
   int                       head_q [CHANNELS] = '{default: 0};
   int                       fill_q [CHANNELS] = '{default: 0};
   int                       sum_q [CHANNELS] = '{default: 0};
   logic signed [DATA_W-1:0] last_q [CHANNELS] = '{default: MARKER_RESET};

   avg_result_type pending_averages [$];
   int          mismatch_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   bit          req_up = 1'b0;
   logic        hold_go = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;

   fault_aware_moving_average_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_channel (rsp_out_channel),
      .rsp_mean_value  (rsp_mean_value),
      .rsp_has_data    (rsp_has_data),
      .rsp_fill_count  (rsp_fill_count),
      .rsp_last_good   (rsp_last_good),
      .rsp_sample_good (rsp_sample_good),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop if the block hangs
   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // Mean of the channel ring after this word; state updates as the block does
   function automatic avg_result_type predict_average(input logic [CH_W-1:0] ch,
                                                     input logic signed [DATA_W-1:0] s);
      avg_result_type r;
      int          v;
      int          pos;
      r.chan = ch;
      r.good = (int'(s) / 16) != (int'(marker_q) / 16);
      r.mean = marker_q;
      r.last = marker_q;
      r.has  = 1'b0;
      r.fill = '0;
      if (ch < CHANNELS) begin
         if (!r.good) begin
            // fault: drop the oldest entry, if any
            if (fill_q[ch] > 0) begin
               sum_q[ch] -= int'(ring_q[ch][head_q[ch]]);
               head_q[ch] = (head_q[ch] + 1) % RING_DEPTH;
               fill_q[ch]--;
            end
         end else begin
            v = int'(s) + int'(cal_q[ch]);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            last_q[ch] = DATA_W'(v);
            if (fill_q[ch] < RING_DEPTH) begin
               pos = (head_q[ch] + fill_q[ch]) % RING_DEPTH;
               ring_q[ch][pos] = DATA_W'(v);
               fill_q[ch]++;
            end else begin
               // full: overwrite the oldest
               sum_q[ch] -= int'(ring_q[ch][head_q[ch]]);
               ring_q[ch][head_q[ch]] = DATA_W'(v);
               head_q[ch] = (head_q[ch] + 1) % RING_DEPTH;
            end
            sum_q[ch] += v;
         end
         r.fill = FILL_W'(fill_q[ch]);
         r.has  = fill_q[ch] > 0;
         r.last = last_q[ch];
         if (fill_q[ch] > 0) r.mean = DATA_W'(sum_q[ch] / fill_q[ch]);
      end
      return r;
   endfunction

   // Random sample whose integer part matches the marker's
   function automatic logic signed [DATA_W-1:0] fault_sample();
      int whole, lo, hi;
      whole = int'(marker_q) / 16;
      lo = (whole > 0) ? whole * 16 : whole * 16 - 15;
      hi = (whole < 0) ? whole * 16 : whole * 16 + 15;
      if (lo < -32768) lo = -32768;
      if (hi > 32767) hi = 32767;
      return DATA_W'(lo + int'($urandom_range(hi - lo)));
   endfunction

   function automatic void compare_field(input string name, input logic signed [31:0] wanted,
                                         input logic signed [31:0] got);
      if (got !== wanted) begin
         $error("%s: expected %0d, actual %0d", name, wanted, got);
         mismatch_count++;
      end
   endfunction

   // Result checker
   always @(posedge clock) begin
      avg_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_averages.size() == 0) begin
            $error("result word with nothing pending, channel %0d", rsp_out_channel);
            mismatch_count++;
         end else begin
            want = pending_averages.pop_front();
            compare_field("out_channel", want.chan, rsp_out_channel);
            compare_field("mean_value", want.mean, rsp_mean_value);
            compare_field("has_data", want.has, rsp_has_data);
            compare_field("fill_count", want.fill, rsp_fill_count);
            compare_field("last_good", want.last, rsp_last_good);
            compare_field("sample_good", want.good, rsp_sample_good);
         end
      end
   end

   // Receiver stall: random, or a long hold-off when requested
   always @(posedge clock) begin
      if (hold_go != hold_seen) begin
         hold_seen <= hold_go;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= $urandom_range(99) < stall_pct;
      end
   end

   task automatic send_sample(input logic [CH_W-1:0] ch, input logic signed [DATA_W-1:0] s);
      int gap;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         gap = $urandom_range(5, 1);
         if (req_up) req_valid <= 1'b0;
         req_up = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_channel <= ch;
      req_sample  <= s;
      req_up = 1'b1;
      do @(posedge clock); while (req_stall);
      pending_averages.push_back(predict_average(ch, s));
   endtask

   task automatic release_req();
      req_valid <= 1'b0;
      req_up = 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending_averages.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic signed [DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_MARKER)
         marker_q = value;
      else if (idx >= REG_CAL_BASE && idx < REG_CAL_BASE + CSR_IDX_W'(CAL_REGS))
         cal_q[idx - REG_CAL_BASE] = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // New marker and random calibrations, extremes now and then
   task automatic load_settings(input logic signed [DATA_W-1:0] marker);
      logic signed [DATA_W-1:0] cal;
      int                       pick;
      write_register(REG_MARKER, marker);
      for (int i = 0; i < CAL_REGS; i++) begin
         pick = $urandom_range(99);
         if (pick < 10)
            cal = 16'sh7FFF;
         else if (pick < 20)
            cal = 16'sh8000;
         else if (pick < 65)
            cal = DATA_W'(int'($urandom_range(1024)) - 512);
         else
            cal = DATA_W'($urandom);
         write_register(REG_CAL_BASE + CSR_IDX_W'(i), cal);
      end
   endtask

   task automatic send_random_item(input int fault_pct);
      logic [CH_W-1:0]          ch;
      logic signed [DATA_W-1:0] s;
      int                       pick;
      if ($urandom_range(99) < 10)
         ch = CH_W'($urandom_range(7, CHANNELS));
      else
         ch = CH_W'($urandom_range(CHANNELS - 1));
      pick = $urandom_range(99);
      if (pick < fault_pct)
         s = fault_sample();
      else if (pick < fault_pct + 8)
         s = $urandom_range(1) ? DATA_W'(32767 - int'($urandom_range(40)))
                               : DATA_W'(-32768 + int'($urandom_range(40)));
      else if (pick < fault_pct + 45)
         s = DATA_W'(int'($urandom_range(4000)) - 2000);
      else
         s = DATA_W'($urandom);
      send_sample(ch, s);
   endtask

   // Reset values: fault on empty rings, fill past depth, drop oldest
   task automatic test_fault_and_fill();
      send_sample(CH_W'(0), fault_sample());
      send_sample(CH_W'(2), fault_sample());
      send_sample(CH_W'(0), 16'sh7FFF);
      send_sample(CH_W'(0), 16'sh8000);
      send_sample(CH_W'(0), fault_sample());
      send_sample(CH_W'(0), fault_sample());
      for (int i = 0; i < RING_DEPTH + 1; i++)
         send_sample(CH_W'(1), DATA_W'(16 * i - 41));
      send_sample(CH_W'(1), fault_sample());
      send_sample(CH_W'(1), fault_sample());
      release_req();
      wait_drained();
   endtask

   // Channels past the last: no state change, marker reported
   task automatic test_out_of_range();
      send_sample(CH_W'(CHANNELS), 16'sd100);
      send_sample(CH_W'(6), fault_sample());
      send_sample(CH_W'(7), 16'sh7FFF);
      release_req();
      wait_drained();
   endtask

   // Marker of zero, calibrations at both extremes, spare indexes ignored
   task automatic test_calibration_saturation();
      write_register(REG_MARKER, 16'sd0);
      write_register(REG_CAL_BASE, 16'sh7FFF);
      write_register(REG_CAL_BASE + CSR_IDX_W'(1), 16'sh8000);
      write_register(REG_CAL_BASE + CSR_IDX_W'(2), 16'sd100);
      write_register(REG_CAL_BASE + CSR_IDX_W'(3), -16'sd100);
      write_register(REG_CAL_BASE + CSR_IDX_W'(4), -16'sd1);
      write_register(REG_SPARE, 16'sh5A5A);
      write_register(REG_SPARE + CSR_IDX_W'(1), 16'shA5A5);
      send_sample(CH_W'(0), 16'sh7FFF);
      send_sample(CH_W'(0), 16'sh8000);
      send_sample(CH_W'(1), 16'sh8000);
      send_sample(CH_W'(1), 16'sh7FFF);
      send_sample(CH_W'(2), 16'sd7);
      send_sample(CH_W'(3), 16'sh8000);
      send_sample(CH_W'(4), -16'sd1);
      send_sample(CH_W'(7), 16'sd5);
      release_req();
      wait_drained();
   endtask

   // Receiver holds off while words keep coming, so the input stalls
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_go <= ~hold_go;
      for (int n = 0; n < 40; n++) send_random_item(20);
      release_req();
      wait_drained();
   endtask

   task automatic test_random_traffic(input int items, input int gap_pct, input int stall_chance);
      int fault_pct;
      send_idle_pct = gap_pct;
      stall_pct = stall_chance;
      fault_pct = 20;
      for (int n = 0; n < items; n++) begin
         // every 60 words, pick at random between mostly filling and mostly draining rings
         if (n % 60 == 0) fault_pct = $urandom_range(1) ? 15 : 55;
         send_random_item(fault_pct);
      end
      release_req();
      wait_drained();
      send_idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fault_and_fill();
      test_out_of_range();
      test_calibration_saturation();
      test_backpressure();

      load_settings(16'sh7FFF);
      test_random_traffic(430, 0, 0);
      load_settings(16'sh8000);
      test_random_traffic(430, 45, 0);
      load_settings(DATA_W'($urandom));
      test_random_traffic(430, 0, 45);
      load_settings(MARKER_RESET);
      test_random_traffic(430, 37, 37);

      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && pending_averages.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/fama_pkg.sv
hdl/fama_div.sv
hdl/fama_dpath.sv
hdl/fama_ctrl.sv
hdl/fault_aware_moving_average_top.sv
test/fault_aware_moving_average_top_tb.sv
